// ----- rtl/emc_pkg.sv -----
// ----------------------------------------------------------------------------
// ElGamal cipher core package
// Word widths, unit command codes and the request and status bundles that
// pass between the sequencer and the modular arithmetic unit.
// ----------------------------------------------------------------------------
package emc_pkg;

    localparam int WORD_W     = 32;
    localparam int CNT_W      = $clog2(WORD_W + 1);
    localparam int IN_DATA_W  = 3 * WORD_W;
    localparam int OUT_DATA_W = 2 * WORD_W;
    localparam int IDX_W      = 2;

    localparam logic [WORD_W-1:0] WORD_ONE = WORD_W'(1);
    localparam logic [WORD_W-1:0] WORD_TWO = WORD_W'(2);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(WORD_W);

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_MODULUS    = 2'd0;
    localparam logic [IDX_W-1:0] REG_GENERATOR  = 2'd1;
    localparam logic [IDX_W-1:0] REG_PUBLIC_KEY = 2'd2;
    localparam logic [IDX_W-1:0] REG_SECRET_KEY = 2'd3;

    // Operation codes carried in tuser.
    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    // Arithmetic unit commands.
    localparam logic CMD_REDUCE = 1'b0;   // op_a mod p
    localparam logic CMD_MULMOD = 1'b1;   // op_a * op_b mod p, op_a below p

    typedef struct packed {
        logic              start;
        logic              cmd;
        logic [WORD_W-1:0] op_a;
        logic [WORD_W-1:0] op_b;
    } mu_req_t;

    typedef struct packed {
        logic done;
    } mu_stat_t;

endpackage

// ----- rtl/emc_mod_unit.sv -----
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// One add, compare and subtract step per cycle. Reduction is a restoring
// remainder, one dividend bit a cycle; the product is MSB-first double and
// add, with the addition cycle taken only for set multiplier bits.
// ----------------------------------------------------------------------------
module emc_mod_unit
    import emc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  mu_req_t           req,
    input  logic [WORD_W-1:0] modulus,
    output mu_stat_t          stat,
    output logic [WORD_W-1:0] result
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              cmd_reg, cmd_next;
    logic              dbl_reg, dbl_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] run_reg, run_next;
    logic [WORD_W-1:0] bits_reg, bits_next;

    logic [WORD_W-1:0] add_b;
    logic              add_cin;
    logic [WORD_W+1:0] sum_w;
    logic [WORD_W+1:0] diff_w;
    logic [WORD_W-1:0] sum_mod;

    // Both addends are below p, so a single conditional subtract suffices.
    always_comb begin
        add_b   = dbl_reg ? acc_reg : run_reg;
        add_cin = (cmd_reg == CMD_REDUCE) ? bits_reg[WORD_W-1] : 1'b0;
        sum_w   = {2'b00, acc_reg} + {2'b00, add_b} + {{(WORD_W+1){1'b0}}, add_cin};
        diff_w  = sum_w - {2'b00, modulus};
        sum_mod = diff_w[WORD_W+1] ? sum_w[WORD_W-1:0] : diff_w[WORD_W-1:0];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cmd_next  = cmd_reg;
        dbl_next  = dbl_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        run_next  = run_reg;
        bits_next = bits_reg;
        if (!busy_reg) begin
            if (req.start) begin
                busy_next = 1'b1;
                cmd_next  = req.cmd;
                dbl_next  = 1'b1;
                cnt_next  = CNT_FULL;
                acc_next  = '0;
                run_next  = req.op_a;
                bits_next = (req.cmd == CMD_REDUCE) ? req.op_a : req.op_b;
            end
        end else begin
            acc_next = sum_mod;
            if (cmd_reg == CMD_MULMOD && dbl_reg && bits_reg[WORD_W-1]) begin
                // Doubling done; the addition of the running operand follows.
                dbl_next = 1'b0;
            end else begin
                dbl_next  = 1'b1;
                bits_next = {bits_reg[WORD_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        dbl_reg  <= dbl_next;
        cnt_reg  <= cnt_next;
        acc_reg  <= acc_next;
        run_reg  <= run_next;
        bits_reg <= bits_next;
    end

    assign stat.done = done_reg;
    assign result    = acc_reg;

endmodule

// ----- rtl/elgamal_mod_exp_cipher_core.sv -----
// ----------------------------------------------------------------------------
// ElGamal cipher core
// Encrypts or decrypts one 32-bit word per item over a configurable prime
// modulus, using one shared modular add unit under a small sequencer.
// ----------------------------------------------------------------------------
// How to use: write the modulus p, generator g, public key h and secret key x
// through the configuration channel while the core is idle, then stream
// items. On an encrypt item the core returns a = g^y mod p and
// c = m * h^y mod p, where y is the ephemeral key reduced mod p; when y
// reduces to zero (or p is zero) the flag bad_key is set and both words are
// zero. On a decrypt item the core computes s = a^x mod p and returns
// c * s^(p-2) mod p, which is c / s for invertible s, with result_a zero.
// All modular arithmetic goes through a single 34-bit add, compare and subtract
// step inside the modular unit, so that step sets the rate. A power skips the
// exponent bits down to the leading one, then makes one squaring for each
// bit below the leading one plus one product per set bit below it.
// An encrypt item runs four reductions, two powers by the reduced key and a
// final product, with less work for a shorter key; the work of a decrypt
// item is set by the bit lengths of x and p. The core takes no new item
// while one is in progress, but a finished result waits in the output
// register so the next item can be accepted before it is taken.
// ----------------------------------------------------------------------------
module elgamal_mod_exp_cipher_core
    import emc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input items.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata fields, lowest bit up: message_value, ephemeral_key, cipher_a
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser fields, lowest bit up: func
    input  logic [0:0]            s_tuser,
    // Result items.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata fields, lowest bit up: result_value, result_a
    output logic [OUT_DATA_W-1:0] m_tdata,
    // m_tuser fields, lowest bit up: bad_key
    output logic [0:0]            m_tuser,
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [WORD_W-1:0]     cfg_data
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_YRED = 4'd1;   // reduce ephemeral key
    localparam logic [3:0] S_GRED = 4'd2;   // reduce generator
    localparam logic [3:0] S_HRED = 4'd3;   // reduce public key
    localparam logic [3:0] S_ARED = 4'd4;   // reduce cipher component a
    localparam logic [3:0] S_POW  = 4'd5;   // exponent bit decisions
    localparam logic [3:0] S_PMUL = 4'd6;   // product inside a power
    localparam logic [3:0] S_MRED = 4'd7;   // reduce message word
    localparam logic [3:0] S_FMUL = 4'd8;   // final product
    localparam logic [3:0] S_DONE = 4'd9;   // hand result to output register

    // Which power is running.
    localparam logic [1:0] POW_G   = 2'd0;
    localparam logic [1:0] POW_H   = 2'd1;
    localparam logic [1:0] POW_X   = 2'd2;
    localparam logic [1:0] POW_INV = 2'd3;

    logic [WORD_W-1:0] mod_reg, gen_reg, pub_reg, sec_reg;

    logic [3:0]        state_reg, state_next;
    logic [WORD_W-1:0] msg_reg, msg_next;
    logic [WORD_W-1:0] key_reg, key_next;
    logic [WORD_W-1:0] sval_reg, sval_next;
    logic [WORD_W-1:0] base_reg, base_next;
    logic [WORD_W-1:0] exp_reg, exp_next;
    logic [WORD_W-1:0] pacc_reg, pacc_next;
    logic [CNT_W-1:0]  pcnt_reg, pcnt_next;
    logic              started_reg, started_next;
    logic              sq_reg, sq_next;
    logic [1:0]        pow_id_reg, pow_id_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic [WORD_W-1:0] ra_reg, ra_next;
    logic              bad_reg, bad_next;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                  m_bad_reg, m_bad_next;

    mu_req_t           mu_req;
    mu_stat_t          mu_stat;
    logic [WORD_W-1:0] mu_result;
    logic [WORD_W-1:0] init_one;
    logic [WORD_W-1:0] pow_value;

    emc_mod_unit u_mod_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mu_req),
        .modulus (mod_reg),
        .stat    (mu_stat),
        .result  (mu_result)
    );

    // 1 mod p, which is zero only for p equal to one.
    assign init_one  = (mod_reg == WORD_ONE) ? '0 : WORD_ONE;
    // A power whose exponent had no set bit is 1 mod p.
    assign pow_value = started_reg ? pacc_reg : init_one;

    // Configuration is taken in any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= WORD_W'(3);
            gen_reg <= WORD_TWO;
            pub_reg <= WORD_ONE;
            sec_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODULUS:    mod_reg <= cfg_data;
                REG_GENERATOR:  gen_reg <= cfg_data;
                REG_PUBLIC_KEY: pub_reg <= cfg_data;
                REG_SECRET_KEY: sec_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        msg_next     = msg_reg;
        key_next     = key_reg;
        sval_next    = sval_reg;
        base_next    = base_reg;
        exp_next     = exp_reg;
        pacc_next    = pacc_reg;
        pcnt_next    = pcnt_reg;
        started_next = started_reg;
        sq_next      = sq_reg;
        pow_id_next  = pow_id_reg;
        res_next     = res_reg;
        ra_next      = ra_reg;
        bad_next     = bad_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_data_next  = m_data_reg;
        m_bad_next   = m_bad_reg;
        mu_req       = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    msg_next  = s_tdata[WORD_W-1:0];
                    res_next  = '0;
                    ra_next   = '0;
                    bad_next  = 1'b0;
                    if (mod_reg == '0) begin
                        // No reduction is possible: encrypt flags the key.
                        bad_next   = (s_tuser[0] == FUNC_ENCRYPT);
                        state_next = S_DONE;
                    end else if (s_tuser[0] == FUNC_ENCRYPT) begin
                        mu_req.start = 1'b1;
                        mu_req.cmd   = CMD_REDUCE;
                        mu_req.op_a  = s_tdata[2*WORD_W-1:WORD_W];
                        state_next   = S_YRED;
                    end else begin
                        mu_req.start = 1'b1;
                        mu_req.cmd   = CMD_REDUCE;
                        mu_req.op_a  = s_tdata[3*WORD_W-1:2*WORD_W];
                        state_next   = S_ARED;
                    end
                end
            end
            S_YRED: begin
                if (mu_stat.done) begin
                    key_next = mu_result;
                    if (mu_result == '0) begin
                        bad_next   = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        mu_req.start = 1'b1;
                        mu_req.cmd   = CMD_REDUCE;
                        mu_req.op_a  = gen_reg;
                        state_next   = S_GRED;
                    end
                end
            end
            S_GRED, S_HRED, S_ARED: begin
                if (mu_stat.done) begin
                    base_next    = mu_result;
                    pcnt_next    = CNT_FULL;
                    started_next = 1'b0;
                    sq_next      = 1'b1;
                    if (state_reg == S_ARED) begin
                        exp_next    = sec_reg;
                        pow_id_next = POW_X;
                    end else if (state_reg == S_GRED) begin
                        exp_next    = key_reg;
                        pow_id_next = POW_G;
                    end else begin
                        exp_next    = key_reg;
                        pow_id_next = POW_H;
                    end
                    state_next = S_POW;
                end
            end
            S_POW: begin
                if (pcnt_reg == '0) begin
                    case (pow_id_reg)
                        POW_G: begin
                            ra_next      = pow_value;
                            mu_req.start = 1'b1;
                            mu_req.cmd   = CMD_REDUCE;
                            mu_req.op_a  = pub_reg;
                            state_next   = S_HRED;
                        end
                        POW_X: begin
                            // s is already reduced; raise it to p-2.
                            base_next    = pow_value;
                            exp_next     = mod_reg - WORD_TWO;
                            pcnt_next    = CNT_FULL;
                            started_next = 1'b0;
                            sq_next      = 1'b1;
                            pow_id_next  = POW_INV;
                        end
                        default: begin
                            sval_next    = pow_value;
                            mu_req.start = 1'b1;
                            mu_req.cmd   = CMD_REDUCE;
                            mu_req.op_a  = msg_reg;
                            state_next   = S_MRED;
                        end
                    endcase
                end else if (!started_reg) begin
                    // Leading zero bits leave the power at one; skip them.
                    if (exp_reg[WORD_W-1]) begin
                        pacc_next    = base_reg;
                        started_next = 1'b1;
                    end
                    exp_next  = {exp_reg[WORD_W-2:0], 1'b0};
                    pcnt_next = pcnt_reg - 1'b1;
                end else begin
                    mu_req.start = 1'b1;
                    mu_req.cmd   = CMD_MULMOD;
                    mu_req.op_a  = pacc_reg;
                    mu_req.op_b  = sq_reg ? pacc_reg : base_reg;
                    state_next   = S_PMUL;
                end
            end
            S_PMUL: begin
                if (mu_stat.done) begin
                    pacc_next  = mu_result;
                    state_next = S_POW;
                    if (sq_reg && exp_reg[WORD_W-1]) begin
                        sq_next = 1'b0;
                    end else begin
                        sq_next   = 1'b1;
                        exp_next  = {exp_reg[WORD_W-2:0], 1'b0};
                        pcnt_next = pcnt_reg - 1'b1;
                    end
                end
            end
            S_MRED: begin
                if (mu_stat.done) begin
                    mu_req.start = 1'b1;
                    mu_req.cmd   = CMD_MULMOD;
                    mu_req.op_a  = mu_result;
                    mu_req.op_b  = sval_reg;
                    state_next   = S_FMUL;
                end
            end
            S_FMUL: begin
                if (mu_stat.done) begin
                    res_next   = mu_result;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {ra_reg, res_reg};
                    m_bad_next   = bad_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        msg_reg     <= msg_next;
        key_reg     <= key_next;
        sval_reg    <= sval_next;
        base_reg    <= base_next;
        exp_reg     <= exp_next;
        pacc_reg    <= pacc_next;
        pcnt_reg    <= pcnt_next;
        started_reg <= started_next;
        sq_reg      <= sq_next;
        pow_id_reg  <= pow_id_next;
        res_reg     <= res_next;
        ra_reg      <= ra_next;
        bad_reg     <= bad_next;
        m_data_reg  <= m_data_next;
        m_bad_reg   <= m_bad_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_bad_reg;

endmodule

// ----- rtl/emc_checker.sv -----
// ----------------------------------------------------------------------------
// ElGamal cipher core port checker
// Watches the ports of the core and flags result or handshake behavior that
// the core must never show.
// ----------------------------------------------------------------------------
module emc_checker
    import emc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [0:0]            m_tuser
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A flagged key always comes with all-zero result words.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("bad key result carries nonzero data");

    // An accepted item keeps the core busy in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("core ready right after accepting an item");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind elgamal_mod_exp_cipher_core emc_checker u_emc_checker (.*);

// ----- tb/elgamal_mod_exp_cipher_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ElGamal cipher core testbench
// Streams encrypt and decrypt items through the core under several key
// settings. A scoreboard predicts each result from its own copy of the key
// registers and checks the results in order. Both sides of the stream stall
// at random, and the result side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module elgamal_mod_exp_cipher_core_tb;
    import emc_pkg::*;

    localparam int TIMEOUT_NS       = 200_000_000;
    localparam int LONG_HOLD_CYCLES = 20000;

    // One result item as the core should present it.
    typedef struct packed {
        logic [WORD_W-1:0] res_value;
        logic [WORD_W-1:0] res_a;
        logic              bad_key;
    } cipher_out_t;

    // Keeps a mirror of the key registers, works out the result of every
    // accepted item and compares the results in arrival order.
    class cipher_scoreboard;
        logic [WORD_W-1:0] modulus    = 32'd3;
        logic [WORD_W-1:0] generator  = 32'd2;
        logic [WORD_W-1:0] public_key = 32'd1;
        logic [WORD_W-1:0] secret_key = 32'd0;
        cipher_out_t       pending_outcomes[$];
        int                errors  = 0;
        int                checked = 0;
        int                flagged = 0;

        // Exact product reduced by md; md must be nonzero.
        function logic [WORD_W-1:0] mul_word(logic [WORD_W-1:0] u, logic [WORD_W-1:0] v,
                                             logic [WORD_W-1:0] md);
            longint unsigned wu, wv, wm;
            wu = u;
            wv = v;
            wm = md;
            return WORD_W'((wu * wv) % wm);
        endfunction

        // Right-to-left square and multiply; md must be nonzero.
        function logic [WORD_W-1:0] pow_word(logic [WORD_W-1:0] base, logic [WORD_W-1:0] e,
                                             logic [WORD_W-1:0] md);
            logic [WORD_W-1:0] acc, sq;
            acc = (md == WORD_ONE) ? '0 : WORD_ONE;
            sq  = base % md;
            for (int i = 0; i < WORD_W; i++) begin
                if (e[i]) acc = mul_word(acc, sq, md);
                sq = mul_word(sq, sq, md);
            end
            return acc;
        endfunction

        function cipher_out_t cipher_outcome(logic op, logic [WORD_W-1:0] msg,
                                             logic [WORD_W-1:0] ekey,
                                             logic [WORD_W-1:0] ca);
            cipher_out_t       r;
            logic [WORD_W-1:0] yr, s, inv;
            r = '0;
            if (op == FUNC_ENCRYPT) begin
                // Without a modulus there is no usable key at all.
                if (modulus == '0) begin
                    r.bad_key = 1'b1;
                end else begin
                    yr = ekey % modulus;
                    if (yr == '0) begin
                        r.bad_key = 1'b1;
                    end else begin
                        r.res_a     = pow_word(generator, yr, modulus);
                        s           = pow_word(public_key, yr, modulus);
                        r.res_value = mul_word(msg, s, modulus);
                    end
                end
            end else if (modulus != '0) begin
                // The inverse exponent wraps for a modulus of one.
                s           = pow_word(ca, secret_key, modulus);
                inv         = pow_word(s, modulus - WORD_TWO, modulus);
                r.res_value = mul_word(msg, inv, modulus);
            end
            return r;
        endfunction

        function void note_config(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val);
            case (idx)
                REG_MODULUS:    modulus    = val;
                REG_GENERATOR:  generator  = val;
                REG_PUBLIC_KEY: public_key = val;
                REG_SECRET_KEY: secret_key = val;
                default: ;
            endcase
        endfunction

        function void note_item(logic op, logic [WORD_W-1:0] msg, logic [WORD_W-1:0] ekey,
                                logic [WORD_W-1:0] ca);
            pending_outcomes.push_back(cipher_outcome(op, msg, ekey, ca));
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        task log_mismatch(string msg);
            if (errors < 200) $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] data, logic [0:0] user);
            cipher_out_t want;
            if (pending_outcomes.size() == 0) begin
                log_mismatch($sformatf("result %h / %b arrived with nothing pending",
                                       data, user));
                return;
            end
            want = pending_outcomes.pop_front();
            checked++;
            if (want.bad_key) flagged++;
            if (data[0 +: WORD_W] !== want.res_value)
                log_mismatch($sformatf("result %0d: result_value %h, predicted %h",
                                       checked, data[0 +: WORD_W], want.res_value));
            if (data[WORD_W +: WORD_W] !== want.res_a)
                log_mismatch($sformatf("result %0d: result_a %h, predicted %h",
                                       checked, data[WORD_W +: WORD_W], want.res_a));
            if (user[0] !== want.bad_key)
                log_mismatch($sformatf("result %0d: bad_key %b, predicted %b",
                                       checked, user[0], want.bad_key));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata fields, lowest bit up: message_value, ephemeral_key, cipher_a
    logic [IN_DATA_W-1:0]  s_tdata;
    // s_tuser fields, lowest bit up: func
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // m_tdata fields, lowest bit up: result_value, result_a
    logic [OUT_DATA_W-1:0] m_tdata;
    // m_tuser fields, lowest bit up: bad_key
    logic [0:0]            m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index;
    logic [WORD_W-1:0]     cfg_data;

    cipher_scoreboard sb = new;

    // Random stalls on both sides are enabled while this is set.
    bit idling;
    // The stimulus raises this once; the result side clears it when its long
    // hold-off is over.
    bit long_hold;

    int n_encrypt;
    int n_decrypt;
    int n_writes;

    elgamal_mod_exp_cipher_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Monitors sample at the rising edge; every input changes at the falling
    // edge, so the values seen here are settled.
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            sb.note_config(cfg_index, cfg_data);
            n_writes++;
        end
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_item(s_tuser[0], s_tdata[0 +: WORD_W], s_tdata[WORD_W +: WORD_W],
                         s_tdata[2*WORD_W +: WORD_W]);
            if (s_tuser[0] == FUNC_ENCRYPT) n_encrypt++;
            else n_decrypt++;
        end
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // Result side: mostly ready, with short random stalls while idling is on,
    // and one long hold-off on request that lets the core fill up.
    initial begin : result_sink
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                long_hold = 1'b0;
                m_tready <= 1'b1;
            end else if (idling && $urandom_range(0, 15) == 0) begin
                n = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one item and returns at the edge that accepts it. The valid
    // stays high on return so back-to-back items need no bubble.
    task automatic send_item(logic op, logic [WORD_W-1:0] msg, logic [WORD_W-1:0] ekey,
                             logic [WORD_W-1:0] ca);
        int gap;
        gap = (idling && $urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ca, ekey, msg};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering and waits until every predicted result has been taken.
    task automatic quiesce();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Keys are only changed once the core has drained.
    task automatic load_keys(logic [WORD_W-1:0] p, logic [WORD_W-1:0] g,
                             logic [WORD_W-1:0] h, logic [WORD_W-1:0] x);
        quiesce();
        write_reg(REG_MODULUS, p);
        write_reg(REG_GENERATOR, g);
        write_reg(REG_PUBLIC_KEY, h);
        write_reg(REG_SECRET_KEY, x);
    endtask

    function automatic logic [WORD_W-1:0] rand_below(logic [WORD_W-1:0] lim);
        return (lim == '0) ? WORD_W'($urandom()) : WORD_W'($urandom()) % lim;
    endfunction

    // A random multiple of the modulus, which must give the bad key flag.
    function automatic logic [WORD_W-1:0] multiple_of(logic [WORD_W-1:0] lim);
        if (lim == '0) return '0;
        return lim * WORD_W'($urandom_range(0, 32'hFFFF_FFFF / lim));
    endfunction

    // Ephemeral keys: mostly full width, sometimes short to vary the work.
    function automatic logic [WORD_W-1:0] pick_ephemeral();
        return ($urandom_range(0, 3) == 0) ? WORD_W'($urandom_range(1, 40))
                                           : WORD_W'($urandom());
    endfunction

    // Most of the traffic is an encryption followed by the decryption of its
    // own ciphertext, so decrypts exercise real inverses. The rest is noise:
    // keys that reduce to zero and encrypts and decrypts of arbitrary words.
    task automatic random_phase(int count);
        cipher_out_t       enc;
        logic [WORD_W-1:0] msg, ekey;
        int                sent;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_item(FUNC_ENCRYPT, $urandom(), multiple_of(sb.modulus), $urandom());
                    sent++;
                end
                1: begin
                    send_item(FUNC_ENCRYPT, $urandom(), $urandom(), $urandom());
                    sent++;
                end
                2: begin
                    send_item(FUNC_DECRYPT, $urandom(), $urandom(), $urandom());
                    sent++;
                end
                default: begin
                    msg  = rand_below(sb.modulus);
                    ekey = pick_ephemeral();
                    enc  = sb.cipher_outcome(FUNC_ENCRYPT, msg, ekey, '0);
                    send_item(FUNC_ENCRYPT, msg, ekey, $urandom());
                    send_item(FUNC_DECRYPT, enc.res_value, $urandom(), enc.res_a);
                    sent += 2;
                end
            endcase
        end
    endtask

    initial begin : stimulus
        logic [WORD_W-1:0] secret;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODULUS;
        cfg_data  = '0;
        idling    = 1'b1;
        long_hold = 1'b0;
        n_encrypt = 0;
        n_decrypt = 0;
        n_writes  = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset keys: p = 3, g = 2, h = 1, x = 0. An all-ones key is a
        // multiple of three, and a zero secret makes the shared value one.
        send_item(FUNC_ENCRYPT, 32'd0, 32'd1, 32'hFFFF_FFFF);
        send_item(FUNC_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_item(FUNC_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_item(FUNC_DECRYPT, 32'd2, 32'd0, 32'hFFFF_FFFF);

        // Largest 32-bit prime with extreme keys. A zero public key zeroes
        // the ciphertext; an a that is a multiple of p has no inverse.
        load_keys(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_item(FUNC_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_item(FUNC_ENCRYPT, 32'd1, 32'hFFFF_FFFB, 32'd0);
        send_item(FUNC_DECRYPT, 32'd12345, 32'd0, 32'hFFFF_FFFB);
        send_item(FUNC_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FUNC_ENCRYPT, 32'd0, 32'd1, 32'd0);

        // Zero modulus: no reduction is possible at all.
        load_keys(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_item(FUNC_ENCRYPT, 32'd1, 32'd1, 32'd0);
        send_item(FUNC_DECRYPT, 32'd5, 32'd0, 32'd5);

        // Modulus one: every key reduces to zero, and the inverse exponent
        // wraps to all ones.
        load_keys(32'd1, 32'd2, 32'd0, 32'hFFFF_FFFF);
        send_item(FUNC_ENCRYPT, 32'd7, 32'd12345, 32'd0);
        send_item(FUNC_DECRYPT, 32'd9, 32'd0, 32'd3);

        // Modulus two: the inverse exponent is zero, so even a zero shared
        // value has power one.
        load_keys(32'd2, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FUNC_ENCRYPT, 32'd1, 32'd1, 32'd0);
        send_item(FUNC_ENCRYPT, 32'd1, 32'd2, 32'd0);
        send_item(FUNC_DECRYPT, 32'd1, 32'd0, 32'd3);
        send_item(FUNC_DECRYPT, 32'hFFFF_FFFF, 32'd0, 32'd2);

        // All-ones modulus, which is not prime, with random keys.
        load_keys(32'hFFFF_FFFF, $urandom(), $urandom(), $urandom());
        send_item(FUNC_ENCRYPT, $urandom(), $urandom(), $urandom());
        send_item(FUNC_DECRYPT, $urandom(), $urandom(), $urandom());

        // Random traffic under proper key pairs, h = g^x mod p.
        secret = $urandom();
        load_keys(32'hFFFF_FFFB, 32'd2, sb.pow_word(32'd2, secret, 32'hFFFF_FFFB), secret);
        random_phase(20);

        // Small prime, so items are short; the long hold-off on the result
        // side makes the core back up and stall its input.
        secret = $urandom();
        load_keys(32'd23, 32'd5, sb.pow_word(32'd5, secret, 32'd23), secret);
        long_hold = 1'b1;
        random_phase(24);

        // First prime above 2^31, where sums overflow 32 bits; no stalls.
        idling = 1'b0;
        secret = $urandom();
        load_keys(32'h8000_000B, 32'd7, sb.pow_word(32'd7, secret, 32'h8000_000B), secret);
        random_phase(20);

        // The sender pauses halfway until every result is back.
        idling = 1'b1;
        secret = $urandom();
        load_keys(32'd65521, 32'd17, sb.pow_word(32'd17, secret, 32'd65521), secret);
        random_phase(10);
        quiesce();
        random_phase(10);

        // Smallest modulus in range: many keys reduce to zero.
        secret = $urandom();
        load_keys(32'd3, 32'd2, sb.pow_word(32'd2, secret, 32'd3), secret);
        random_phase(16);

        // The last part runs without any stalls.
        idling = 1'b0;
        secret = $urandom();
        load_keys(32'd257, 32'd3, sb.pow_word(32'd3, secret, 32'd257), secret);
        random_phase(20);

        quiesce();
        repeat (50) @(posedge aclk);

        $display("Ran %0d encrypt and %0d decrypt items under %0d register writes,",
                 n_encrypt, n_decrypt, n_writes);
        $display("checked %0d results, %0d of them with the bad key flag; %0d mismatches.",
                 sb.checked, sb.flagged, sb.errors);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still outstanding", sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
